FILE: sv/kws_pkg.sv
package kws_pkg;

  localparam int KW_COUNT = 14;
  localparam int KW_IDX_W = 4;
  localparam int WIN_BYTES = 24;
  localparam int WIN_W = WIN_BYTES * 8;
  localparam int CMP_W = WIN_W + 8;
  localparam int STATUS_W = 11;

  localparam logic signed [STATUS_W-1:0] STATUS_OK = 11'sd200;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } kws_cmd_t;

  // keyword text, last character in the low byte
  localparam logic [CMP_W-1:0] KW_TEXT [KW_COUNT] = '{
    CMP_W'("password"),
    CMP_W'("passwd"),
    CMP_W'("secret"),
    CMP_W'("token"),
    CMP_W'("api_key"),
    CMP_W'("apikey"),
    CMP_W'({"DB_", "PASSWORD"}),
    CMP_W'("DB_PASS"),
    CMP_W'({"AWS_", "SECRET"}),
    CMP_W'({"private", "_key"}),
    CMP_W'("BEGIN RSA PRIVATE KEY"),
    CMP_W'("BEGIN OPENSSH PRIVATE KEY"),
    CMP_W'("Authorization"),
    CMP_W'("credentials")
  };

  localparam int KW_LEN [KW_COUNT] = '{8, 6, 6, 5, 7, 6, 11, 7, 10, 11, 21, 25, 13, 11};

  // control from the top level into the scan state
  typedef struct packed {
    logic body;
    logic finish;
  } kws_step_t;

  // summary of the scan, valid before the end word clears it
  typedef struct packed {
    logic                found;
    logic [KW_IDX_W-1:0] index;
  } kws_scan_t;

  function automatic logic [KW_IDX_W-1:0] first_index(input logic [KW_COUNT-1:0] flags);
    logic [KW_IDX_W-1:0] idx;
    idx = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (flags[i]) begin
        idx = KW_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: sv/sensitive_keyword_scanner_top.sv
// result: an end word's result is loaded into the output registers at the edge where the word
//   leaves the input register; body words give no result
// throughput: one word per cycle, body bytes compared combinationally against a 25-byte window;
//   an end word waits in the input register only while a stalled result holds the output
// reset: synchronous, clears window, found flags, byte count, text end and both pipeline valids
module sensitive_keyword_scanner_top #(
  parameter int SNIPPET_LEN = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic [7:0]                           body_byte,
  input  logic signed [kws_pkg::STATUS_W-1:0]  resp_status,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [kws_pkg::STATUS_W-1:0]  status_out,
  output logic                                 kw_found,
  output logic [kws_pkg::KW_IDX_W-1:0]         keyword_index
);
  import kws_pkg::*;

  logic                       r_valid;
  kws_cmd_t                   r_cmd;
  logic [7:0]                 r_byte;
  logic signed [STATUS_W-1:0] r_status;

  logic      accept;
  logic      advance;
  kws_step_t step;
  kws_scan_t scan;

  // body words never need the output slot
  assign advance  = r_valid && ((r_cmd == CMD_BYTE) || !out_valid || !out_stall);
  assign in_stall = r_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign step.body   = advance && (r_cmd == CMD_BYTE);
  assign step.finish = advance && (r_cmd == CMD_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (accept) begin
      r_valid <= 1'b1;
    end else if (advance) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_cmd    <= kws_cmd_t'(command);
      r_byte   <= body_byte;
      r_status <= resp_status;
    end
  end

  kws_state #(
    .SNIPPET_LEN (SNIPPET_LEN)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .body_byte (r_byte),
    .scan      (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.finish) begin
      status_out    <= r_status;
      kw_found      <= (r_status == STATUS_OK) && scan.found;
      keyword_index <= ((r_status == STATUS_OK) && scan.found) ? scan.index : '0;
    end
  end

endmodule

FILE: sv/kws_match.sv
module kws_match (
  input  logic [kws_pkg::CMP_W-1:0]    text,
  output logic [kws_pkg::KW_COUNT-1:0] hit
);
  import kws_pkg::*;

  // one masked comparator per keyword against the tail of the window
  for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
    localparam logic [CMP_W-1:0] MASK = {CMP_W{1'b1}} >> (CMP_W - 8 * KW_LEN[k]);
    assign hit[k] = ((text ^ KW_TEXT[k]) & MASK) == '0;
  end

endmodule

FILE: sv/kws_state.sv
module kws_state #(
  parameter int SNIPPET_LEN = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kws_pkg::kws_step_t   step,
  input  logic [7:0]           body_byte,
  output kws_pkg::kws_scan_t   scan
);
  import kws_pkg::*;

  localparam int CNT_W = (SNIPPET_LEN > 2) ? $clog2(SNIPPET_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SNIPPET_LEN - 1);

  logic [WIN_W-1:0]    window;
  logic [KW_COUNT-1:0] found_flags;
  logic [CNT_W-1:0]    stored_count;
  logic                text_ended;

  logic [KW_COUNT-1:0] hit;
  logic                room;
  logic                searched;

  kws_match u_match (
    .text ({window, body_byte}),
    .hit  (hit)
  );

  assign room     = stored_count != CNT_MAX;
  assign searched = step.body && room && !text_ended && (body_byte != 8'd0);

  always_ff @(posedge clk) begin
    if (rst || step.finish) begin
      window       <= '0;
      found_flags  <= '0;
      stored_count <= '0;
      text_ended   <= 1'b0;
    end else if (step.body && room) begin
      stored_count <= stored_count + 1'b1;
      if (searched) begin
        window      <= {window[WIN_W-9:0], body_byte};
        found_flags <= found_flags | hit;
      end
      // a zero byte ends the searchable text
      if (body_byte == 8'd0) begin
        text_ended <= 1'b1;
      end
    end
  end

  always_comb begin
    scan.found = (stored_count != '0) && (found_flags != '0);
    scan.index = first_index(found_flags);
  end

endmodule

FILE: sv/kws_checker.sv
module kws_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [kws_pkg::STATUS_W-1:0] status_out,
  input logic                                kw_found,
  input logic [kws_pkg::KW_IDX_W-1:0]        keyword_index
);
  import kws_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status_out) && $stable(kw_found)
      && $stable(keyword_index))
    else $error("stalled result changed");

  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kw_found |-> keyword_index == '0)
    else $error("index nonzero without keyword");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kw_found |-> (status_out == STATUS_OK)
      && (keyword_index < KW_IDX_W'(KW_COUNT)))
    else $error("keyword reported on bad status or index");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind sensitive_keyword_scanner_top kws_checker u_kws_checker (.*);

FILE: tb/sv/kws_report_checker.sv
module kws_report_checker #(
  parameter int SNIPPET_LEN = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 command,
  input  logic [7:0]                           body_byte,
  input  logic signed [kws_pkg::STATUS_W-1:0]  resp_status,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [kws_pkg::STATUS_W-1:0]  status_out,
  input  logic                                 kw_found,
  input  logic [kws_pkg::KW_IDX_W-1:0]         keyword_index,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   report_count,
  output int                                   hit_count
);
  import kws_pkg::*;

  typedef struct {
    logic signed [STATUS_W-1:0] status;
    logic                       has;
    logic [KW_IDX_W-1:0]        idx;
  } kw_report_t;

  string keywords [KW_COUNT] = '{
    "password", "passwd", "secret", "token", "api_key", "apikey",
    string'({"DB_", "PASSWORD"}), "DB_PASS", string'({"AWS_", "SECRET"}),
    string'({"private", "_key"}), "BEGIN RSA PRIVATE KEY",
    "BEGIN OPENSSH PRIVATE KEY", "Authorization", "credentials"
  };

  logic [7:0]          tail_bytes [WIN_BYTES];
  logic [KW_COUNT-1:0] seen_kw;
  int                  bytes_kept;
  logic                text_done;
  kw_report_t          expected_reports [$];

  function automatic void clear_scan();
    foreach (tail_bytes[i]) tail_bytes[i] = 8'd0;
    seen_kw = '0;
    bytes_kept = 0;
    text_done = 1'b0;
  endfunction

  // compare every keyword against the tail window ending in the new byte
  function automatic void scan_text_byte(input logic [7:0] b);
    int n;
    int pos;
    logic hit;
    logic [7:0] c;
    for (int k = 0; k < KW_COUNT; k++) begin
      n = keywords[k].len();
      hit = 1'b1;
      for (int j = 0; j < n; j++) begin
        pos = WIN_BYTES + 1 - n + j;
        c = (pos == WIN_BYTES) ? b : tail_bytes[pos];
        if (c != keywords[k].getc(j)) hit = 1'b0;
      end
      if (hit) seen_kw[k] = 1'b1;
    end
    for (int i = 0; i < WIN_BYTES - 1; i++) tail_bytes[i] = tail_bytes[i+1];
    tail_bytes[WIN_BYTES-1] = b;
  endfunction

  function automatic kw_report_t finish_response(input logic signed [STATUS_W-1:0] st);
    kw_report_t r;
    r.status = st;
    r.has = 1'b0;
    r.idx = '0;
    if (st == STATUS_OK && bytes_kept > 0 && seen_kw != '0) begin
      r.has = 1'b1;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (seen_kw[k]) r.idx = KW_IDX_W'(k);
      end
    end
    return r;
  endfunction

  initial begin
    clear_scan();
    fail_count = 0;
    pending = 0;
    report_count = 0;
    hit_count = 0;
  end

  always @(posedge clk) begin : watch
    kw_report_t want;
    if (rst) begin
      clear_scan();
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        report_count++;
        if (expected_reports.size() == 0) begin
          $error("unexpected result word: status_out %0d", status_out);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (status_out !== want.status) begin
            $error("status_out: expected %0d, got %0d", want.status, status_out);
            fail_count++;
          end
          if (kw_found !== want.has) begin
            $error("kw_found: expected %0d, got %0d", want.has, kw_found);
            fail_count++;
          end
          if (keyword_index !== want.idx) begin
            $error("keyword_index: expected %0d, got %0d", want.idx, keyword_index);
            fail_count++;
          end
          if (want.has) hit_count++;
        end
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_END) begin
          expected_reports.push_back(finish_response(resp_status));
          clear_scan();
        end else if (bytes_kept < SNIPPET_LEN - 1) begin
          bytes_kept++;
          // a zero byte ends the searchable text but still counts as kept
          if (!text_done) begin
            if (body_byte == 8'd0) text_done = 1'b1;
            else scan_text_byte(body_byte);
          end
        end
      end
    end
    pending = expected_reports.size();
  end

endmodule

FILE: tb/sv/tb.sv
module tb;
  import kws_pkg::*;

  // small snippet size so the byte limit is reached often
  localparam int SNIP_LEN = 40;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       command;
  logic [7:0]                 body_byte;
  logic signed [STATUS_W-1:0] resp_status;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [STATUS_W-1:0] status_out;
  logic                       kw_found;
  logic [KW_IDX_W-1:0]        keyword_index;

  int   fail_count;
  int   pending;
  int   report_count;
  int   hit_count;
  int   word_count;
  logic calm;
  logic gappy;
  logic held;

  // keywords plus near misses and overlaps
  string phrases [20] = '{
    "password", "passwd", "secret", "token", "api_key", "apikey",
    string'({"DB_", "PASSWORD"}), "DB_PASS", string'({"AWS_", "SECRET"}),
    string'({"private", "_key"}), "BEGIN RSA PRIVATE KEY",
    "BEGIN OPENSSH PRIVATE KEY", "Authorization", "credentials",
    "passwor", "Secret", "tokn", "DB_PAS", "api-key", "BEGIN RSA PRIVATE"
  };
  string letters = "abcdeiknoprstwyABDEGIKNOPRSTWY_ -";

  sensitive_keyword_scanner_top #(.SNIPPET_LEN(SNIP_LEN)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .body_byte(body_byte), .resp_status(resp_status),
    .out_valid(out_valid), .out_stall(out_stall),
    .status_out(status_out), .kw_found(kw_found), .keyword_index(keyword_index)
  );

  kws_report_checker #(.SNIPPET_LEN(SNIP_LEN)) u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .body_byte(body_byte), .resp_status(resp_status),
    .out_valid(out_valid), .out_stall(out_stall),
    .status_out(status_out), .kw_found(kw_found), .keyword_index(keyword_index),
    .fail_count(fail_count), .pending(pending),
    .report_count(report_count), .hit_count(hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic send_word(input kws_cmd_t cmd, input logic [7:0] b,
                           input logic signed [STATUS_W-1:0] st);
    int gap;
    if (!calm && gappy && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        body_byte <= 8'($urandom);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    body_byte <= b;
    resp_status <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    word_count++;
  endtask

  // unused field carries random bits
  task automatic send_byte(input logic [7:0] b);
    send_word(CMD_BYTE, b, STATUS_W'($urandom));
  endtask

  task automatic send_end(input logic signed [STATUS_W-1:0] st);
    send_word(CMD_END, 8'($urandom), st);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s.getc(i));
  endtask

  task automatic send_response();
    int len;
    int pick;
    string s;
    logic signed [STATUS_W-1:0] st;
    gappy = ($urandom_range(0, 2) != 0);
    case ($urandom_range(0, 9))
      0:       len = 0;
      1, 2:    len = $urandom_range(SNIP_LEN - 8, SNIP_LEN + 12);
      default: len = $urandom_range(1, 20);
    endcase
    while (len > 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        s = phrases[$urandom_range(0, 19)];
        send_text(s);
        len -= s.len();
      end else begin
        if (pick == 3) send_byte(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom));
        else if (pick < 8) send_byte(letters.getc($urandom_range(0, letters.len() - 1)));
        else send_byte(8'($urandom_range(1, 255)));
        len--;
      end
    end
    case ($urandom_range(0, 11))
      8:       st = -11'sd1;
      9:       st = STATUS_W'($urandom_range(0, 999));
      10:      st = STATUS_W'($urandom);
      11:      st = ($urandom_range(0, 1) == 0) ? 11'sd199 : 11'sd201;
      default: st = STATUS_OK;
    endcase
    send_end(st);
  endtask

  // receiver: random stall bursts, one long hold-off to back the block up
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && report_count >= 3) begin
        held = 1'b1;
        repeat (250) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      n = $urandom_range(1, 30);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      if (!calm) begin
        n = $urandom_range(1, 13);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_BYTE;
    body_byte = 8'd0;
    resp_status = '0;
    word_count = 0;
    calm = 1'b0;
    gappy = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: plain hit, empty body, text cut by a zero byte,
    // failed transfer, non-200 status with a keyword present
    send_text("token");
    send_end(STATUS_OK);
    send_end(STATUS_OK);
    send_byte(8'h00);
    send_text("token");
    send_end(STATUS_OK);
    send_byte(8'hff);
    send_end(-11'sd1);
    send_text("apikey");
    send_end(11'sd201);

    while (word_count < 1000) begin
      if (word_count > 850) calm = 1'b1;
      send_response();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("sent %0d words, checked %0d end-of-response reports, %0d with a keyword hit",
             word_count, report_count, hit_count);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/kws_pkg.sv
sv/kws_match.sv
sv/kws_state.sv
sv/sensitive_keyword_scanner_top.sv
sv/kws_checker.sv
tb/sv/kws_report_checker.sv
tb/sv/tb.sv
